// File: design/iwp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwp_pkg
// Shared types and constants for the int8 window pooling unit.
// ----------------------------------------------------------------------------
package iwp_pkg;

    localparam int MaxHeight = 64;
    localparam int MaxWidth  = 64;
    localparam int MaxWindow = 16;

    localparam int RowW  = $clog2(MaxHeight);
    localparam int ColW  = $clog2(MaxWidth);
    localparam int AddrW = RowW + ColW;
    localparam int WinW  = $clog2(MaxWindow + 1);
    localparam int TapW  = $clog2(MaxWindow);
    localparam int SumW  = 8 + 2 * TapW + 1;
    localparam int AreaW = 2 * WinW;

    // Tap coordinates span output index * stride plus window, minus pad
    localparam int CoordW = 17;

    localparam logic signed [7:0] PadMax = -8'sd128;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_WINDOW_H = 3'd1,
        REG_WINDOW_W = 3'd2,
        REG_STRIDES  = 3'd3,
        REG_PADS     = 3'd4,
        REG_ZERO_PT  = 3'd5,
        REG_IN_H     = 3'd6,
        REG_IN_W     = 3'd7
    } reg_idx_t;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load_wr;   // write pixel into the store
        logic init;      // latch origin, clear accumulators
        logic tap_issue; // issue read for current tap, advance counters
        logic tap_acc;   // accumulate tap issued last cycle
        logic div_start; // set up divider
        logic div_step;  // one restoring divide step
        logic finish;    // drive result strobe
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_tap;  // current tap is the last of the window
        logic div_done;  // divider is doing its last step
        logic avg_mode;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage
`default_nettype wire

// File: design/iwp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwp_datapath
// Plane store, tap address generation, max/sum accumulation and a
// bit-serial divider for the rounded average.
// ----------------------------------------------------------------------------
module iwp_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic [9:0]          row,
    input  wire logic [9:0]          col,
    input  wire logic signed [7:0]   pixel,
    input  wire iwp_pkg::dp_cmd_t    cmd,
    output iwp_pkg::dp_stat_t        stat,
    output logic signed [7:0]        pooled,
    output logic                     strobe
);
    import iwp_pkg::*;

    // Configuration registers
    logic             mode_reg;
    logic [4:0]       win_h_reg, win_w_reg;
    logic [7:0]       strides_reg;
    logic [15:0]      pads_reg;
    logic signed [7:0] zp_reg;
    logic [6:0]       in_h_reg, in_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            win_h_reg   <= 5'd1;
            win_w_reg   <= 5'd1;
            strides_reg <= '0;
            pads_reg    <= '0;
            zp_reg      <= '0;
            in_h_reg    <= 7'd1;
            in_w_reg    <= 7'd1;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:     mode_reg    <= cfg_data[0];
                REG_WINDOW_H: win_h_reg   <= cfg_data[4:0];
                REG_WINDOW_W: win_w_reg   <= cfg_data[4:0];
                REG_STRIDES:  strides_reg <= cfg_data[7:0];
                REG_PADS:     pads_reg    <= cfg_data;
                REG_ZERO_PT:  zp_reg      <= cfg_data[7:0];
                REG_IN_H:     in_h_reg    <= cfg_data[6:0];
                REG_IN_W:     in_w_reg    <= cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    // Effective sizes
    logic [WinW-1:0] kh, kw;
    logic [6:0]      eff_h, eff_w;
    always_comb
    begin
        kh = (win_h_reg == 5'd0) ? WinW'(1) :
             (win_h_reg > 5'(MaxWindow)) ? WinW'(MaxWindow) : WinW'(win_h_reg);
        kw = (win_w_reg == 5'd0) ? WinW'(1) :
             (win_w_reg > 5'(MaxWindow)) ? WinW'(MaxWindow) : WinW'(win_w_reg);
        eff_h = (in_h_reg > 7'(MaxHeight)) ? 7'(MaxHeight) : in_h_reg;
        eff_w = (in_w_reg > 7'(MaxWidth))  ? 7'(MaxWidth)  : in_w_reg;
    end

    // Plane store
    logic [7:0]       mem [0:MaxHeight*MaxWidth-1];
    logic [AddrW-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             load_ok;
    assign load_ok = (row < 10'(eff_h)) && (col < 10'(eff_w));

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_ok)
            mem[{row[RowW-1:0], col[ColW-1:0]}] <= pixel;
        rd_data <= mem[rd_addr];
    end

    // Window origin and tap counters
    logic signed [CoordW-1:0] oy_reg, ox_reg;
    logic [TapW-1:0]          ti_reg, tj_reg;
    logic signed [CoordW-1:0] iy, ix;
    logic                     in_img, in_img_reg;
    logic [14:0]              prod_y, prod_x;

    assign prod_y = row * (5'(strides_reg[7:4]) + 5'd1);
    assign prod_x = col * (5'(strides_reg[3:0]) + 5'd1);
    assign iy = oy_reg + CoordW'(ti_reg);
    assign ix = ox_reg + CoordW'(tj_reg);
    assign in_img = (iy >= 0) && (ix >= 0) &&
                    (iy < CoordW'(eff_h)) && (ix < CoordW'(eff_w));
    assign rd_addr = {iy[RowW-1:0], ix[ColW-1:0]};
    assign stat.last_tap = (WinW'(ti_reg) == kh - 1'b1) && (WinW'(tj_reg) == kw - 1'b1);
    assign stat.avg_mode = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ti_reg <= '0;
            tj_reg <= '0;
        end
        else if (cmd.init)
        begin
            ti_reg <= '0;
            tj_reg <= '0;
        end
        else if (cmd.tap_issue)
        begin
            if (WinW'(tj_reg) == kw - 1'b1)
            begin
                tj_reg <= '0;
                ti_reg <= ti_reg + 1'b1;
            end
            else
                tj_reg <= tj_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            oy_reg <= CoordW'(prod_y) - CoordW'(pads_reg[15:8]);
            ox_reg <= CoordW'(prod_x) - CoordW'(pads_reg[7:0]);
        end
        in_img_reg <= in_img;
    end

    // Accumulation of max and sum
    logic signed [7:0]      tap_v, best_reg;
    logic signed [SumW-1:0] sum_reg;
    assign tap_v = in_img_reg ? $signed(rd_data) : (mode_reg ? zp_reg : PadMax);

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            best_reg <= PadMax;
            sum_reg  <= '0;
        end
        else if (cmd.tap_acc)
        begin
            if (tap_v > best_reg)
                best_reg <= tap_v;
            sum_reg <= sum_reg + SumW'(tap_v);
        end
    end

    // Restoring divider: (|sum| + n/2) / n, one quotient bit per step
    localparam int DivW = SumW;
    logic [AreaW-1:0]       area_reg;
    logic [DivW-1:0]        num_reg, quo_reg;
    logic [DivW:0]          rem_reg, rem_try;
    logic [$clog2(DivW+1)-1:0] cnt_reg;
    logic                   neg_reg;
    logic [AreaW-1:0]       area;
    logic [DivW-1:0]        abs_sum;

    assign area    = kh * kw;
    assign abs_sum = sum_reg[SumW-1] ? DivW'(-sum_reg) : DivW'(sum_reg);
    assign rem_try = {rem_reg[DivW-1:0], num_reg[DivW-1]};
    assign stat.div_done = (cnt_reg == 1);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            area_reg <= area;
            num_reg  <= abs_sum + DivW'(area >> 1);
            neg_reg  <= sum_reg[SumW-1];
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= ($clog2(DivW+1))'(DivW);
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            cnt_reg <= cnt_reg - 1'b1;
            if (rem_try >= (DivW+1)'(area_reg))
            begin
                rem_reg <= rem_try - (DivW+1)'(area_reg);
                quo_reg <= {quo_reg[DivW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[DivW-2:0], 1'b0};
            end
        end
    end

    // Tie to even: even area, zero remainder, odd quotient
    logic [7:0] q_fix;
    assign q_fix = (!area_reg[0] && rem_reg == '0 && quo_reg[0]) ?
                   quo_reg[7:0] - 8'd1 : quo_reg[7:0];

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe <= 1'b0;
        else
            strobe <= cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            pooled <= mode_reg ? (neg_reg ? -$signed(q_fix) : $signed(q_fix)) : best_reg;
    end

endmodule
`default_nettype wire

// File: design/iwp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwp_ctrl
// Sequencer: walks the window taps, then runs the divider in average mode.
// ----------------------------------------------------------------------------
module iwp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             opcode,
    input  wire iwp_pkg::dp_stat_t stat,
    output iwp_pkg::dp_cmd_t      cmd,
    output logic                  busy
);
    import iwp_pkg::*;

    state_t  state_reg, state_next;
    logic    accept;
    logic    acc_reg, div_go_reg;
    dp_cmd_t cmd_base;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        cmd_base         = '0;
        cmd_base.load_wr = accept && (opcode == OP_LOAD);
        cmd_base.init    = accept && (opcode == OP_COMPUTE);
        unique case (state_reg)
            ST_IDLE:
                if (accept && opcode == OP_COMPUTE)
                    state_next = ST_SCAN;
            ST_SCAN:
            begin
                cmd_base.tap_issue = 1'b1;
                if (stat.last_tap)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                // last tap's data lands this cycle
                state_next = stat.avg_mode ? ST_DIV : ST_DONE;
            ST_DIV:
            begin
                // first cycle is divider setup, the counter is not valid yet
                if (stat.div_done && !div_go_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd_base.finish = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Accumulate in the cycle after each issued tap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            acc_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= cmd_base.tap_issue;
        end
    end

    // Divider setup happens in the first DIV cycle, steps follow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_go_reg <= 1'b0;
        else
            div_go_reg <= (state_reg == ST_DRAIN) && stat.avg_mode;
    end

    always_comb
    begin
        cmd           = cmd_base;
        cmd.tap_acc   = acc_reg;
        cmd.div_start = div_go_reg;
        cmd.div_step  = (state_reg == ST_DIV) && !div_go_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> (state_reg == ST_IDLE))
        else $error("done not followed by idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && stat.last_tap |=> (state_reg == ST_DRAIN))
        else $error("scan did not end on last tap");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_go_reg |-> (state_reg == ST_DIV))
        else $error("divider setup outside divide state");

endmodule
`default_nettype wire

// File: design/int8_window_pool_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// int8_window_pool_unit
// Int8 max / average pooling over a window of up to 16x16 on a 64x64 plane.
// ----------------------------------------------------------------------------
// A load writes one pixel into the store. A compute reads the store once per
// tap and, in average mode, then runs a one-bit-per-cycle divider. busy is
// high while a compute runs; the result appears on pooled with done high for
// one cycle and cannot be held off.
module int8_window_pool_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              opcode,
    input  wire logic [9:0]        row,
    input  wire logic [9:0]        col,
    input  wire logic signed [7:0] pixel,
    output logic signed [7:0]      pooled
);
    import iwp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    iwp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    iwp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row       (row),
        .col       (col),
        .pixel     (pixel),
        .cmd       (cmd),
        .stat      (stat),
        .pooled    (pooled),
        .strobe    (done)
    );

endmodule
`default_nettype wire
